// File: src/cee_pkg.sv
`default_nettype none
package cee_pkg;

	localparam int unsigned FUNC_W   = 5;
	localparam int unsigned ADDR_W   = 64;
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned COP_W    = 2;
	localparam int unsigned STAT_W   = 6;
	localparam int unsigned CODE_W   = 5;
	localparam int unsigned VAUPD_W  = 2;
	localparam int unsigned VPN_SH   = 13;
	localparam int unsigned VPN_W    = ADDR_W - VPN_SH;
	localparam int unsigned REGION_SH = 62;
	localparam int unsigned REGION_W = ADDR_W - REGION_SH;

	// exception kinds
	localparam logic [FUNC_W-1:0] FN_ADDR_ERR  = 5'd0;
	localparam logic [FUNC_W-1:0] FN_BREAK     = 5'd1;
	localparam logic [FUNC_W-1:0] FN_BUS       = 5'd2;
	localparam logic [FUNC_W-1:0] FN_COLD      = 5'd3;
	localparam logic [FUNC_W-1:0] FN_COP_UNUSE = 5'd4;
	localparam logic [FUNC_W-1:0] FN_FP        = 5'd5;
	localparam logic [FUNC_W-1:0] FN_OVF       = 5'd6;
	localparam logic [FUNC_W-1:0] FN_INT       = 5'd7;
	localparam logic [FUNC_W-1:0] FN_NMI       = 5'd8;
	localparam logic [FUNC_W-1:0] FN_RI        = 5'd9;
	localparam logic [FUNC_W-1:0] FN_RI_COP2   = 5'd10;
	localparam logic [FUNC_W-1:0] FN_SOFT      = 5'd11;
	localparam logic [FUNC_W-1:0] FN_SYS       = 5'd12;
	localparam logic [FUNC_W-1:0] FN_TLB_INV   = 5'd13;
	localparam logic [FUNC_W-1:0] FN_TLB_MISS  = 5'd14;
	localparam logic [FUNC_W-1:0] FN_TLB_MOD   = 5'd15;
	localparam logic [FUNC_W-1:0] FN_TRAP      = 5'd16;
	localparam logic [FUNC_W-1:0] FN_WATCH     = 5'd17;
	localparam logic [FUNC_W-1:0] FN_XTLB_MISS = 5'd18;

	// access kinds
	localparam logic [KIND_W-1:0] ACC_READ  = 2'd0;
	localparam logic [KIND_W-1:0] ACC_WRITE = 2'd1;
	localparam logic [KIND_W-1:0] ACC_FETCH = 2'd2;

	// status bit positions
	localparam int unsigned ST_EXL = 0;
	localparam int unsigned ST_ERL = 1;
	localparam int unsigned ST_BEV = 2;
	localparam int unsigned ST_SR  = 3;
	localparam int unsigned ST_TS  = 4;
	localparam int unsigned ST_RP  = 5;

	// cause codes
	localparam logic [CODE_W-1:0] EXC_INT   = 5'd0;
	localparam logic [CODE_W-1:0] EXC_MOD   = 5'd1;
	localparam logic [CODE_W-1:0] EXC_TLBL  = 5'd2;
	localparam logic [CODE_W-1:0] EXC_TLBS  = 5'd3;
	localparam logic [CODE_W-1:0] EXC_ADEL  = 5'd4;
	localparam logic [CODE_W-1:0] EXC_ADES  = 5'd5;
	localparam logic [CODE_W-1:0] EXC_IBE   = 5'd6;
	localparam logic [CODE_W-1:0] EXC_DBE   = 5'd7;
	localparam logic [CODE_W-1:0] EXC_SYS   = 5'd8;
	localparam logic [CODE_W-1:0] EXC_BP    = 5'd9;
	localparam logic [CODE_W-1:0] EXC_RI    = 5'd10;
	localparam logic [CODE_W-1:0] EXC_CPU   = 5'd11;
	localparam logic [CODE_W-1:0] EXC_OV    = 5'd12;
	localparam logic [CODE_W-1:0] EXC_TR    = 5'd13;
	localparam logic [CODE_W-1:0] EXC_FPE   = 5'd15;
	localparam logic [CODE_W-1:0] EXC_WATCH = 5'd23;

	localparam logic [COP_W-1:0] CE_COP2 = 2'd2;

	// bad address update kinds
	localparam logic [VAUPD_W-1:0] VA_NONE   = 2'd0;
	localparam logic [VAUPD_W-1:0] VA_VPN    = 2'd1;
	localparam logic [VAUPD_W-1:0] VA_REGION = 2'd2;

	// vectors
	localparam logic [ADDR_W-1:0] VEC_COMMON_BEV = 64'hFFFF_FFFF_BFC0_0380;
	localparam logic [ADDR_W-1:0] VEC_COMMON     = 64'hFFFF_FFFF_8000_0180;
	localparam logic [ADDR_W-1:0] VEC_RESET      = 64'hFFFF_FFFF_BFC0_0000;
	localparam logic [ADDR_W-1:0] VEC_TLB        = 64'hFFFF_FFFF_8000_0000;
	localparam logic [ADDR_W-1:0] VEC_TLB_BEV    = 64'hFFFF_FFFF_BFC0_0200;
	localparam logic [ADDR_W-1:0] VEC_XTLB       = 64'hFFFF_FFFF_8000_0080;
	localparam logic [ADDR_W-1:0] VEC_XTLB_BEV   = 64'hFFFF_FFFF_BFC0_0280;

	localparam logic [ADDR_W-1:0] INSN_BYTES = 64'd4;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [ADDR_W-1:0] current_pc;
		logic              delay_slot;
		logic [ADDR_W-1:0] fault_address;
		logic [KIND_W-1:0] access_kind;
		logic [COP_W-1:0]  coprocessor_number;
		logic [STAT_W-1:0] status_in;
		logic [ADDR_W-1:0] error_return_pc;
	} evt_t;

	typedef struct packed {
		logic [ADDR_W-1:0]   next_pc;
		logic [STAT_W-1:0]   status_out;
		logic                epc_write;
		logic [ADDR_W-1:0]   epc_value;
		logic                branch_delay;
		logic                cause_code_write;
		logic [CODE_W-1:0]   cause_code;
		logic                ce_write;
		logic [COP_W-1:0]    coprocessor_error;
		logic [VAUPD_W-1:0]  vaddr_update;
		logic [VPN_W-1:0]    vpn2_value;
		logic [REGION_W-1:0] region_value;
	} res_t;

endpackage
`default_nettype wire

// File: src/cee_evt_if.sv
`default_nettype none
interface cee_evt_if;
	import cee_pkg::*;

	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [ADDR_W-1:0] current_pc;
	logic              delay_slot;
	logic [ADDR_W-1:0] fault_address;
	logic [KIND_W-1:0] access_kind;
	logic [COP_W-1:0]  coprocessor_number;
	logic [STAT_W-1:0] status_in;
	logic [ADDR_W-1:0] error_return_pc;

	modport source (
		output valid, func, current_pc, delay_slot, fault_address,
			access_kind, coprocessor_number, status_in, error_return_pc,
		input  ready
	);
	modport sink (
		input  valid, func, current_pc, delay_slot, fault_address,
			access_kind, coprocessor_number, status_in, error_return_pc,
		output ready
	);
endinterface
`default_nettype wire

// File: src/cee_res_if.sv
`default_nettype none
interface cee_res_if;
	import cee_pkg::*;

	logic                valid;
	logic                ready;
	logic [ADDR_W-1:0]   next_pc;
	logic [STAT_W-1:0]   status_out;
	logic                epc_write;
	logic [ADDR_W-1:0]   epc_value;
	logic                branch_delay;
	logic                cause_code_write;
	logic [CODE_W-1:0]   cause_code;
	logic                ce_write;
	logic [COP_W-1:0]    coprocessor_error;
	logic [VAUPD_W-1:0]  vaddr_update;
	logic [VPN_W-1:0]    vpn2_value;
	logic [REGION_W-1:0] region_value;

	modport source (
		output valid, next_pc, status_out, epc_write, epc_value, branch_delay,
			cause_code_write, cause_code, ce_write, coprocessor_error, vaddr_update,
			vpn2_value, region_value,
		input  ready
	);
	modport sink (
		input  valid, next_pc, status_out, epc_write, epc_value, branch_delay,
			cause_code_write, cause_code, ce_write, coprocessor_error, vaddr_update,
			vpn2_value, region_value,
		output ready
	);
endinterface
`default_nettype wire

// File: src/cpu_exception_entry_unit.sv
// Exception entry unit: turns one exception event into the next pc, the new
// status bits and the cp0 register updates (epc, branch delay, cause code,
// cause ce, badvaddr / vpn2 / region).
// Channels: evt (sink) carries one event item, res (source) one result item,
// both valid/ready; an item moves on a rising edge with valid and ready high.
// Every event gives exactly one result, in order.
// Pipeline: the event sits in the input register, then the decode and vector
// mux load the result register, whose valid bit drives res.valid.
// Throughput: one item per cycle; evt.ready is high whenever either stage is
// empty or the result register is being drained.
// Stall: when res.ready is low the result register holds; the input register
// takes one more item only if it is empty, then evt.ready drops until res drains.
// evt.ready is combinational from res.ready through the two stage valids.
// Reset (arst_n low) empties both stages; no result is pending afterward.
`default_nettype none
module cpu_exception_entry_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	cee_evt_if.sink   evt,
	cee_res_if.source res
);
	import cee_pkg::*;

	logic valid_s1;
	logic valid_s2;
	evt_t evt_s1;
	res_t res_s2;
	res_t res_c;
	logic adv_s2;
	logic adv_s1;

	assign adv_s2    = !valid_s2 || res.ready;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign evt.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= evt.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && evt.valid) begin
			evt_s1.func               <= evt.func;
			evt_s1.current_pc         <= evt.current_pc;
			evt_s1.delay_slot         <= evt.delay_slot;
			evt_s1.fault_address      <= evt.fault_address;
			evt_s1.access_kind        <= evt.access_kind;
			evt_s1.coprocessor_number <= evt.coprocessor_number;
			evt_s1.status_in          <= evt.status_in;
			evt_s1.error_return_pc    <= evt.error_return_pc;
		end
		if (adv_s2 && valid_s1) begin
			res_s2 <= res_c;
		end
	end

	always_comb begin
		logic              bev;
		logic              exl;
		logic              known;
		logic [ADDR_W-1:0] common;
		logic [CODE_W-1:0] ls_code;
		logic [STAT_W-1:0] st;

		bev     = evt_s1.status_in[ST_BEV];
		exl     = evt_s1.status_in[ST_EXL];
		known   = (evt_s1.func <= FN_XTLB_MISS);
		common  = bev ? VEC_COMMON_BEV : VEC_COMMON;
		ls_code = (evt_s1.access_kind == ACC_WRITE) ? EXC_TLBS : EXC_TLBL;
		st      = evt_s1.status_in;

		res_c = '0;
		res_c.next_pc = common;

		if (known && !exl) begin
			res_c.epc_write    = 1'b1;
			res_c.epc_value    = evt_s1.delay_slot ?
				evt_s1.current_pc - INSN_BYTES : evt_s1.current_pc;
			res_c.branch_delay = evt_s1.delay_slot;
			st[ST_EXL]         = 1'b1;
		end

		// most kinds write both cause fields; cold and soft reset clear both below, nmi only the cause code
		res_c.cause_code_write = known;
		res_c.ce_write         = known;

		case (evt_s1.func)
			FN_ADDR_ERR: begin
				res_c.cause_code   = (evt_s1.access_kind == ACC_WRITE) ? EXC_ADES : EXC_ADEL;
				res_c.vaddr_update = VA_REGION;
			end
			FN_BREAK: res_c.cause_code = EXC_BP;
			FN_BUS: res_c.cause_code = (evt_s1.access_kind == ACC_FETCH) ? EXC_IBE : EXC_DBE;
			FN_COLD: begin
				res_c.next_pc          = VEC_RESET;
				res_c.cause_code_write = 1'b0;
				res_c.ce_write         = 1'b0;
				st[ST_RP]              = 1'b0;
				st[ST_SR]              = 1'b0;
				st[ST_TS]              = 1'b0;
				st[ST_ERL]             = 1'b1;
				st[ST_BEV]             = 1'b1;
			end
			FN_COP_UNUSE: begin
				res_c.cause_code        = EXC_CPU;
				res_c.coprocessor_error = evt_s1.coprocessor_number;
			end
			FN_FP: res_c.cause_code = EXC_FPE;
			FN_OVF: res_c.cause_code = EXC_OV;
			FN_INT: res_c.cause_code = EXC_INT;
			FN_NMI: begin
				res_c.next_pc          = evt_s1.error_return_pc;
				res_c.cause_code_write = 1'b0;
				st[ST_TS]              = 1'b0;
				st[ST_ERL]             = 1'b1;
				st[ST_SR]              = 1'b1;
				st[ST_BEV]             = 1'b1;
			end
			FN_RI: res_c.cause_code = EXC_RI;
			FN_RI_COP2: begin
				res_c.cause_code        = EXC_RI;
				res_c.coprocessor_error = CE_COP2;
			end
			FN_SOFT: begin
				res_c.next_pc          = evt_s1.status_in[ST_ERL] ?
					VEC_RESET : evt_s1.error_return_pc;
				res_c.cause_code_write = 1'b0;
				res_c.ce_write         = 1'b0;
				st[ST_RP]              = 1'b0;
				st[ST_TS]              = 1'b0;
				st[ST_BEV]             = 1'b1;
				st[ST_ERL]             = 1'b1;
				st[ST_SR]              = 1'b1;
			end
			FN_SYS: res_c.cause_code = EXC_SYS;
			FN_TLB_INV: begin
				res_c.cause_code   = ls_code;
				res_c.vaddr_update = VA_VPN;
			end
			FN_TLB_MISS: begin
				// refill vector only when exl was clear, else the common one
				if (!exl) begin
					res_c.next_pc = bev ? VEC_TLB_BEV : VEC_TLB;
				end
				res_c.cause_code   = ls_code;
				res_c.vaddr_update = VA_VPN;
			end
			FN_TLB_MOD: begin
				res_c.cause_code   = EXC_MOD;
				res_c.vaddr_update = VA_VPN;
			end
			FN_TRAP: res_c.cause_code = EXC_TR;
			FN_WATCH: res_c.cause_code = EXC_WATCH;
			FN_XTLB_MISS: begin
				if (!exl) begin
					res_c.next_pc = bev ? VEC_XTLB_BEV : VEC_XTLB;
				end
				res_c.cause_code   = ls_code;
				res_c.vaddr_update = VA_REGION;
			end
			default: begin
				// not an exception: pass the pc through, touch nothing
				res_c.next_pc = evt_s1.current_pc;
			end
		endcase

		res_c.status_out = st;
		if (res_c.vaddr_update != VA_NONE) begin
			res_c.vpn2_value = evt_s1.fault_address[ADDR_W-1:VPN_SH];
		end
		if (res_c.vaddr_update == VA_REGION) begin
			res_c.region_value = evt_s1.fault_address[ADDR_W-1:REGION_SH];
		end
	end

	assign res.valid             = valid_s2;
	assign res.next_pc           = res_s2.next_pc;
	assign res.status_out        = res_s2.status_out;
	assign res.epc_write         = res_s2.epc_write;
	assign res.epc_value         = res_s2.epc_value;
	assign res.branch_delay      = res_s2.branch_delay;
	assign res.cause_code_write  = res_s2.cause_code_write;
	assign res.cause_code        = res_s2.cause_code;
	assign res.ce_write          = res_s2.ce_write;
	assign res.coprocessor_error = res_s2.coprocessor_error;
	assign res.vaddr_update      = res_s2.vaddr_update;
	assign res.vpn2_value        = res_s2.vpn2_value;
	assign res.region_value      = res_s2.region_value;

endmodule
`default_nettype wire

// File: tb/sv/tb_cpu_exception_entry_unit.sv
`default_nettype none
module tb_cpu_exception_entry_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import cee_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 1200;

	logic clk;
	logic arst_n;

	cee_evt_if evt();
	cee_res_if res();

	cpu_exception_entry_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.evt(evt),
		.res(res)
	);

	evt_t drive_evt;
	res_t res_seen;

	assign {evt.func, evt.current_pc, evt.delay_slot, evt.fault_address, evt.access_kind,
		evt.coprocessor_number, evt.status_in, evt.error_return_pc} = drive_evt;
	assign res_seen = {res.next_pc, res.status_out, res.epc_write, res.epc_value,
		res.branch_delay, res.cause_code_write, res.cause_code, res.ce_write,
		res.coprocessor_error, res.vaddr_update, res.vpn2_value, res.region_value};

	evt_t queued_exceptions[$];
	res_t predicted_entries[$];

	int mismatches = 0;
	int n_events = 0;
	int n_results = 0;
	int epc_writes = 0;
	int vaddr_writes = 0;
	int cycle_count = 0;
	int gap_left;
	int stall_left;
	int handed;
	logic calm;
	logic [31:0] kinds_seen = '0;

	function automatic res_t predict_entry(input evt_t e);
		res_t r;
		logic [STAT_W-1:0] st;
		logic bev;
		logic exl;
		logic [CODE_W-1:0] tlb_code;
		r = '0;
		st = e.status_in;
		bev = st[ST_BEV];
		exl = st[ST_EXL];
		tlb_code = (e.access_kind == ACC_WRITE) ? EXC_TLBS : EXC_TLBL;
		// unknown kinds pass straight through, nothing written
		if (e.func > FN_XTLB_MISS) begin
			r.next_pc = e.current_pc;
			r.status_out = st;
			return r;
		end
		if (!exl) begin
			r.epc_write = 1'b1;
			r.epc_value = e.delay_slot ? e.current_pc - INSN_BYTES : e.current_pc;
			r.branch_delay = e.delay_slot;
			st[ST_EXL] = 1'b1;
		end
		r.next_pc = bev ? VEC_COMMON_BEV : VEC_COMMON;
		r.cause_code_write = 1'b1;
		r.ce_write = 1'b1;
		case (e.func)
			FN_ADDR_ERR: begin
				r.cause_code = (e.access_kind == ACC_WRITE) ? EXC_ADES : EXC_ADEL;
				r.vaddr_update = VA_REGION;
			end
			FN_BREAK: r.cause_code = EXC_BP;
			FN_BUS: r.cause_code = (e.access_kind == ACC_FETCH) ? EXC_IBE : EXC_DBE;
			FN_COLD: begin
				r.next_pc = VEC_RESET;
				r.cause_code_write = 1'b0;
				r.ce_write = 1'b0;
				st[ST_RP] = 1'b0;
				st[ST_SR] = 1'b0;
				st[ST_TS] = 1'b0;
				st[ST_ERL] = 1'b1;
				st[ST_BEV] = 1'b1;
			end
			FN_COP_UNUSE: begin
				r.cause_code = EXC_CPU;
				r.coprocessor_error = e.coprocessor_number;
			end
			FN_FP: r.cause_code = EXC_FPE;
			FN_OVF: r.cause_code = EXC_OV;
			FN_INT: r.cause_code = EXC_INT;
			FN_NMI: begin
				// ce is still written, as zero
				r.next_pc = e.error_return_pc;
				r.cause_code_write = 1'b0;
				st[ST_TS] = 1'b0;
				st[ST_ERL] = 1'b1;
				st[ST_SR] = 1'b1;
				st[ST_BEV] = 1'b1;
			end
			FN_RI: r.cause_code = EXC_RI;
			FN_RI_COP2: begin
				r.cause_code = EXC_RI;
				r.coprocessor_error = CE_COP2;
			end
			FN_SOFT: begin
				r.next_pc = e.status_in[ST_ERL] ? VEC_RESET : e.error_return_pc;
				r.cause_code_write = 1'b0;
				r.ce_write = 1'b0;
				st[ST_RP] = 1'b0;
				st[ST_TS] = 1'b0;
				st[ST_BEV] = 1'b1;
				st[ST_ERL] = 1'b1;
				st[ST_SR] = 1'b1;
			end
			FN_SYS: r.cause_code = EXC_SYS;
			FN_TLB_INV: begin
				r.cause_code = tlb_code;
				r.vaddr_update = VA_VPN;
			end
			FN_TLB_MISS: begin
				// refill vector picked by bev and exl on entry
				if (bev)
					r.next_pc = exl ? VEC_COMMON_BEV : VEC_TLB_BEV;
				else
					r.next_pc = exl ? VEC_COMMON : VEC_TLB;
				r.cause_code = tlb_code;
				r.vaddr_update = VA_VPN;
			end
			FN_TLB_MOD: begin
				r.cause_code = EXC_MOD;
				r.vaddr_update = VA_VPN;
			end
			FN_TRAP: r.cause_code = EXC_TR;
			FN_WATCH: r.cause_code = EXC_WATCH;
			default: begin
				if (bev)
					r.next_pc = exl ? VEC_COMMON_BEV : VEC_XTLB_BEV;
				else
					r.next_pc = exl ? VEC_COMMON : VEC_XTLB;
				r.cause_code = tlb_code;
				r.vaddr_update = VA_REGION;
			end
		endcase
		r.status_out = st;
		if (r.vaddr_update != VA_NONE)
			r.vpn2_value = VPN_W'(e.fault_address >> VPN_SH);
		if (r.vaddr_update == VA_REGION)
			r.region_value = REGION_W'(e.fault_address >> REGION_SH);
		return r;
	endfunction

	// mostly random words, with the ends and sign-extended kernel addresses mixed in
	function automatic logic [ADDR_W-1:0] rand_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return {32'hFFFF_FFFF, 32'($urandom)};
			default: return {32'($urandom), 32'($urandom)};
		endcase
	endfunction

	function automatic evt_t rand_event();
		evt_t e;
		if ($urandom_range(0, 9) == 0)
			e.func = FUNC_W'($urandom_range(int'(FN_XTLB_MISS) + 1, (1 << FUNC_W) - 1));
		else
			e.func = FUNC_W'($urandom_range(0, int'(FN_XTLB_MISS)));
		e.current_pc = rand_word();
		e.delay_slot = 1'($urandom);
		e.fault_address = rand_word();
		e.access_kind = KIND_W'($urandom);
		e.coprocessor_number = COP_W'($urandom);
		e.status_in = STAT_W'($urandom);
		e.error_return_pc = rand_word();
		return e;
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("cpu_exception_entry_unit: mismatch");
			$finish;
		end
	end

	// event side driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt.valid <= 1'b0;
			drive_evt <= '0;
			gap_left <= 0;
			handed <= 0;
			calm <= 1'b0;
		end else begin
			// no gaps or result stalls in every third stretch of 64 items, nor near the end
			calm <= (queued_exceptions.size() < 150) || (((handed >> 6) % 3) == 2);
			if (!evt.valid || evt.ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					evt.valid <= 1'b0;
				end else if (queued_exceptions.size() != 0 && !calm
						&& $urandom_range(0, 6) == 0) begin
					gap_left <= $urandom_range(0, 2);
					evt.valid <= 1'b0;
				end else if (queued_exceptions.size() != 0) begin
					evt.valid <= 1'b1;
					drive_evt <= queued_exceptions.pop_front();
					handed <= handed + 1;
				end else begin
					evt.valid <= 1'b0;
				end
			end
		end
	end

	// result side back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			res.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 2);
			res.ready <= 1'b0;
		end else begin
			res.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_results
		res_t want;
		string diffs;
		if (arst_n) begin
			if (evt.valid && evt.ready) begin
				predicted_entries.push_back(predict_entry(drive_evt));
				kinds_seen[drive_evt.func] = 1'b1;
				n_events++;
			end
			if (res.valid && res.ready) begin
				n_results++;
				if (predicted_entries.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result item %0d arrived with none pending: %h",
							n_results, res_seen);
				end else begin
					want = predicted_entries.pop_front();
					epc_writes += want.epc_write;
					vaddr_writes += (want.vaddr_update != VA_NONE);
					diffs = "";
					if (res_seen.next_pc !== want.next_pc)
						diffs = {diffs, $sformatf(" next_pc %h/%h", want.next_pc, res_seen.next_pc)};
					if (res_seen.status_out !== want.status_out)
						diffs = {diffs, $sformatf(" status_out %b/%b", want.status_out,
							res_seen.status_out)};
					if (res_seen.epc_write !== want.epc_write)
						diffs = {diffs, $sformatf(" epc_write %b/%b", want.epc_write,
							res_seen.epc_write)};
					if (res_seen.epc_value !== want.epc_value)
						diffs = {diffs, $sformatf(" epc_value %h/%h", want.epc_value,
							res_seen.epc_value)};
					if (res_seen.branch_delay !== want.branch_delay)
						diffs = {diffs, $sformatf(" branch_delay %b/%b", want.branch_delay,
							res_seen.branch_delay)};
					if (res_seen.cause_code_write !== want.cause_code_write)
						diffs = {diffs, $sformatf(" cause_code_write %b/%b", want.cause_code_write,
							res_seen.cause_code_write)};
					if (res_seen.cause_code !== want.cause_code)
						diffs = {diffs, $sformatf(" cause_code %0d/%0d", want.cause_code,
							res_seen.cause_code)};
					if (res_seen.ce_write !== want.ce_write)
						diffs = {diffs, $sformatf(" ce_write %b/%b", want.ce_write,
							res_seen.ce_write)};
					if (res_seen.coprocessor_error !== want.coprocessor_error)
						diffs = {diffs, $sformatf(" coprocessor_error %0d/%0d",
							want.coprocessor_error, res_seen.coprocessor_error)};
					if (res_seen.vaddr_update !== want.vaddr_update)
						diffs = {diffs, $sformatf(" vaddr_update %0d/%0d", want.vaddr_update,
							res_seen.vaddr_update)};
					if (res_seen.vpn2_value !== want.vpn2_value)
						diffs = {diffs, $sformatf(" vpn2_value %h/%h", want.vpn2_value,
							res_seen.vpn2_value)};
					if (res_seen.region_value !== want.region_value)
						diffs = {diffs, $sformatf(" region_value %0d/%0d", want.region_value,
							res_seen.region_value)};
					if (diffs != "") begin
						mismatches++;
						if (mismatches <= 10)
							$display("result item %0d differs (expected/actual):%s", n_results,
								diffs);
					end
				end
			end
		end
	end

	initial begin
		evt_t e;
		int real_items;
		arst_n = 1'b0;

		// every exception kind once, fields pushed to their ends
		for (int f = 0; f <= int'(FN_XTLB_MISS); f++) begin
			e.func = FUNC_W'(f);
			e.current_pc = f[0] ? '1 : 64'hFFFF_FFFF_8000_1234;
			e.delay_slot = f[0];
			e.fault_address = f[1] ? '1 : '0;
			e.access_kind = KIND_W'(f);
			e.coprocessor_number = COP_W'(f >> 1);
			e.status_in = STAT_W'(f * 13);
			e.error_return_pc = {32'hA5A5_0000 | 32'(f), 32'h0000_5A5A};
			queued_exceptions.push_back(e);
		end
		// soft reset with erl set, then clear
		e = rand_event();
		e.func = FN_SOFT;
		e.status_in = '0;
		e.status_in[ST_ERL] = 1'b1;
		queued_exceptions.push_back(e);
		e.status_in = '0;
		queued_exceptions.push_back(e);
		// cold reset with every status bit set
		e = rand_event();
		e.func = FN_COLD;
		e.status_in = '1;
		queued_exceptions.push_back(e);
		// address error with the unused access kind
		e = rand_event();
		e.func = FN_ADDR_ERR;
		e.access_kind = '1;
		e.status_in = '0;
		queued_exceptions.push_back(e);
		// delay slot at pc zero wraps the epc
		e = rand_event();
		e.func = FN_BREAK;
		e.current_pc = '0;
		e.delay_slot = 1'b1;
		e.status_in = '0;
		queued_exceptions.push_back(e);
		// unknown kinds at both ends of the unused range
		e = rand_event();
		e.func = FN_XTLB_MISS + 1'b1;
		queued_exceptions.push_back(e);
		e.func = '1;
		queued_exceptions.push_back(e);

		real_items = 0;
		while (real_items < RANDOM_ITEMS) begin
			e = rand_event();
			queued_exceptions.push_back(e);
			real_items++;
		end

		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		do
			@(negedge clk);
		while (queued_exceptions.size() != 0 || evt.valid || predicted_entries.size() != 0);
		repeat (8) @(negedge clk);

		$display("checked %0d result items for %0d accepted events over %0d distinct kinds",
			n_results, n_events, $countones(kinds_seen));
		$display("%0d entries wrote epc, %0d updated the bad address group",
			epc_writes, vaddr_writes);
		if (mismatches == 0)
			$display("cpu_exception_entry_unit: match");
		else
			$display("cpu_exception_entry_unit: mismatch");
		$finish;
	end

endmodule
`default_nettype wire
